[rtl/msgd_pkg.sv]
// Shared constants, types and fixed-point helpers of the momentum SGD update block.
package msgd_pkg;

  localparam int DEF_WEIGHT_ENTRIES = 4096;
  localparam int DEF_BIAS_ENTRIES   = 256;

  localparam int VAL_W   = 32;  // Q16.16 values
  localparam int COEF_W  = 16;  // Q0.16 coefficients
  localparam int IDX_W   = 12;
  localparam int EPOCH_W = 8;   // clear generation tag kept beside each velocity
  localparam int WORD_W  = EPOCH_W + VAL_W;
  localparam int PROD_W  = VAL_W + COEF_W + 1;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int TERM_W  = DIFF_W - COEF_W;
  localparam int SUM_W   = TERM_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LRATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NESTEROV = 2'd2;

  localparam logic [COEF_W-1:0] MOMENTUM_RST = 16'd58982;
  localparam logic [COEF_W-1:0] LRATE_RST    = 16'd655;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic SEL_WEIGHT = 1'b0;
  localparam logic SEL_BIAS   = 1'b1;

  typedef struct packed {
    logic              sat;
    logic [VAL_W-1:0]  val;
  } sat_res_t;

  // Q16.32 -> Q16.16, round half up (add half an LSB, then floor).
  function automatic logic signed [TERM_W-1:0] rnd_q16(input logic signed [DIFF_W-1:0] x);
    logic signed [DIFF_W-1:0] y;
    y = x + DIFF_W'(32768);
    return y[DIFF_W-1:COEF_W];
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic sat_res_t sat32(input logic signed [SUM_W-1:0] x);
    sat_res_t r;
    r.sat = 1'b0;
    r.val = x[VAL_W-1:0];
    if (!((&x[SUM_W-1:VAL_W-1]) || !(|x[SUM_W-1:VAL_W-1]))) begin
      r.sat = 1'b1;
      r.val = x[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/msgd_vel_ram.sv]
// Velocity store: one write port, one read port, registered read data.
module msgd_vel_ram
  import msgd_pkg::*;
#(
  parameter int DEPTH = DEF_WEIGHT_ENTRIES,
  parameter int WIDTH = WORD_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/momentum_sgd_update_top.sv]
// Momentum SGD update block (standard or Nesterov) over two velocity memories.
//
// Input stream s_axis_*: one word per element update or clear; tuser carries cmd and
// store_sel, tdata carries index, param_in and gradient. Output stream m_axis_*: one
// word per input word; tdata is param_out, tuser is the saturation flag.
// Config channel cfg_*: always ready; write momentum, learning rate and Nesterov mode
// only while the block is idle.
// After accept, an update steps through ST_READ, ST_VEL and ST_ADD (Nesterov adds
// ST_MUL2 and ST_TERM after ST_VEL) to ST_DONE; a clear or an out-of-range index goes
// straight to ST_DONE. Items are processed one at a time by a sequencer around the
// velocity memory read-modify-write, so the block takes no new word until the
// sequencer returns to idle as the result enters the output register.
// The output register holds a finished result while the receiver stalls; the next
// word is accepted meanwhile, and its result waits in the sequencer until the output
// register frees up.
// Reset clears all control and starts a sweep over max(WEIGHT_ENTRIES, BIAS_ENTRIES)
// entries that tags every velocity entry invalid; s_axis_tready stays low during it.
// A clear bumps a generation tag instead of touching memory; every 255th clear
// repeats the same sweep.
module momentum_sgd_update_top
  import msgd_pkg::*;
#(
  parameter int WEIGHT_ENTRIES = DEF_WEIGHT_ENTRIES,
  parameter int BIAS_ENTRIES   = DEF_BIAS_ENTRIES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [79:0]           s_axis_tdata,  // index[11:0], param_in[43:12], gradient[75:44], zero
  input  logic [1:0]            s_axis_tuser,  // cmd[0], store_sel[1]
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // param_out[31:0]
  output logic [0:0]            m_axis_tuser   // saturated[0]
);

  localparam int WA   = (WEIGHT_ENTRIES > 1) ? $clog2(WEIGHT_ENTRIES) : 1;
  localparam int BA   = (BIAS_ENTRIES > 1) ? $clog2(BIAS_ENTRIES) : 1;
  localparam int MAXD = (WEIGHT_ENTRIES > BIAS_ENTRIES) ? WEIGHT_ENTRIES : BIAS_ENTRIES;
  localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_VEL  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_TERM = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // configuration
  logic [COEF_W-1:0] mom_q, lr_q;
  logic              nest_q;

  // sequencer
  logic [2:0]                 state_q;
  logic                       sel_q;
  logic [IDX_W-1:0]           idx_q;
  logic signed [VAL_W-1:0]    w_q, g_q, vn_q;
  logic signed [PROD_W-1:0]   prod_q, lrg_q;
  logic signed [TERM_W-1:0]   term_q;
  logic [VAL_W-1:0]           res_q;
  logic                       flag_q;
  logic [EPOCH_W-1:0]         epoch_q;
  logic                       sweep_q;
  logic [CW-1:0]              sweep_cnt_q;

  // output register
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_data_q;
  logic              out_sat_q;

  // input fields
  logic                    in_cmd, in_sel;
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_w, in_g;
  logic                    in_acc, in_range;

  // memory ports
  logic              w_we, w_re, b_we, b_re;
  logic [WA-1:0]     w_waddr;
  logic [BA-1:0]     b_waddr;
  logic [WORD_W-1:0] mem_wdata, w_rdata, b_rdata, rd_word;

  // datapath
  logic signed [VAL_W-1:0]  v_old;
  logic signed [DIFF_W-1:0] diff;
  logic signed [TERM_W-1:0] rnd;
  sat_res_t                 vel_sat, res_sat;

  assign in_cmd = s_axis_tuser[0];
  assign in_sel = s_axis_tuser[1];
  assign in_idx = s_axis_tdata[11:0];
  assign in_w   = s_axis_tdata[43:12];
  assign in_g   = s_axis_tdata[75:44];

  assign in_range = (in_sel == SEL_BIAS) ? (32'(in_idx) < 32'(BIAS_ENTRIES))
                                         : (32'(in_idx) < 32'(WEIGHT_ENTRIES));

  assign s_axis_tready = (state_q == ST_IDLE) && !sweep_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mom_q  <= MOMENTUM_RST;
      lr_q   <= LRATE_RST;
      nest_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MOMENTUM: mom_q  <= cfg_data_i;
        CFG_LRATE:    lr_q   <= cfg_data_i;
        CFG_NESTEROV: nest_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stored velocity counts only if its tag matches the current generation.
  assign rd_word = (sel_q == SEL_BIAS) ? b_rdata : w_rdata;
  assign v_old   = (rd_word[WORD_W-1:VAL_W] == epoch_q) ? rd_word[VAL_W-1:0] : '0;

  assign diff    = {prod_q[PROD_W-1], prod_q} - {lrg_q[PROD_W-1], lrg_q};
  assign rnd     = rnd_q16(diff);
  assign vel_sat = sat32({rnd[TERM_W-1], rnd});
  assign res_sat = sat32({{(SUM_W-VAL_W){w_q[VAL_W-1]}}, w_q} + {term_q[TERM_W-1], term_q});

  // One item in flight at a time: the write in ST_VEL lands before the next read.
  assign w_we = ((state_q == ST_VEL) && (sel_q == SEL_WEIGHT)) ||
                (sweep_q && (32'(sweep_cnt_q) < 32'(WEIGHT_ENTRIES)));
  assign b_we = ((state_q == ST_VEL) && (sel_q == SEL_BIAS)) ||
                (sweep_q && (32'(sweep_cnt_q) < 32'(BIAS_ENTRIES)));
  assign w_waddr   = sweep_q ? WA'(sweep_cnt_q) : WA'(idx_q);
  assign b_waddr   = sweep_q ? BA'(sweep_cnt_q) : BA'(idx_q);
  assign mem_wdata = sweep_q ? '0 : {epoch_q, vel_sat.val};
  assign w_re = in_acc && (in_cmd == CMD_UPDATE) && (in_sel == SEL_WEIGHT);
  assign b_re = in_acc && (in_cmd == CMD_UPDATE) && (in_sel == SEL_BIAS);

  msgd_vel_ram #(.DEPTH(WEIGHT_ENTRIES), .WIDTH(WORD_W)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (mem_wdata),
    .re_i    (w_re),
    .raddr_i (WA'(in_idx)),
    .rdata_o (w_rdata)
  );

  msgd_vel_ram #(.DEPTH(BIAS_ENTRIES), .WIDTH(WORD_W)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (mem_wdata),
    .re_i    (b_re),
    .raddr_i (BA'(in_idx)),
    .rdata_o (b_rdata)
  );

  // sequencer and generation tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      epoch_q     <= EPOCH_W'(1);
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      flag_q      <= 1'b0;
    end else begin
      if (sweep_q) begin
        if (sweep_cnt_q == CW'(MAXD - 1)) begin
          sweep_q     <= 1'b0;
          sweep_cnt_q <= '0;
        end else begin
          sweep_cnt_q <= sweep_cnt_q + 1'b1;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            flag_q <= 1'b0;
            if (in_cmd == CMD_CLEAR) begin
              // tag 0 is what the sweep writes; generations run 1..max
              if (epoch_q == {EPOCH_W{1'b1}}) begin
                epoch_q <= EPOCH_W'(1);
                sweep_q <= 1'b1;
              end else begin
                epoch_q <= epoch_q + 1'b1;
              end
              state_q <= ST_DONE;
            end else if (!in_range) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: state_q <= ST_VEL;
        ST_VEL: begin
          flag_q  <= vel_sat.sat;
          state_q <= nest_q ? ST_MUL2 : ST_ADD;
        end
        ST_MUL2: state_q <= ST_TERM;
        ST_TERM: state_q <= ST_ADD;
        ST_ADD: begin
          flag_q  <= flag_q | res_sat.sat;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sel_q <= in_sel;
          idx_q <= in_idx;
          w_q   <= in_w;
          g_q   <= in_g;
          res_q <= (in_cmd == CMD_CLEAR) ? '0 : in_w;
        end
      end
      ST_READ: begin
        prod_q <= $signed({1'b0, mom_q}) * v_old;
        lrg_q  <= $signed({1'b0, lr_q}) * g_q;
      end
      ST_VEL: begin
        vn_q   <= vel_sat.val;
        term_q <= {{(TERM_W-VAL_W){vel_sat.val[VAL_W-1]}}, vel_sat.val};
      end
      ST_MUL2: prod_q <= $signed({1'b0, mom_q}) * vn_q;
      ST_TERM: term_q <= rnd;
      ST_ADD:  res_q  <= res_sat.val;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= res_q;
      out_sat_q  <= flag_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;

  // Tag 0 marks swept entries; the live generation must never be 0.
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("generation tag reached reserved value");

  a_sweep_no_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> (state_q == ST_IDLE || state_q == ST_DONE))
    else $error("memory sweep overlaps a read-modify-write");

  a_wrap_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_cmd == CMD_CLEAR) && (epoch_q == {EPOCH_W{1'b1}})) |=> sweep_q)
    else $error("tag wrap without sweep");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("output word loaded outside completion");

endmodule

[tb/momentum_sgd_update_top_tb.sv]
// Self-checking testbench for the momentum SGD update block: directed and random update streams.
module momentum_sgd_update_top_tb;
  import msgd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register, writes ignored

  typedef struct {
    logic                    cmd;
    logic                    sel;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] param_in;
    logic signed [VAL_W-1:0] gradient;
  } upd_t;

  typedef struct {
    logic [VAL_W-1:0] val;
    logic             sat;
  } param_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // index[11:0], param_in[43:12], gradient[75:44], zero
  logic [1:0] s_axis_tuser = '0;   // cmd[0], store_sel[1]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // param_out[31:0]
  logic [0:0] m_axis_tuser;        // saturated[0]

  momentum_sgd_update_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // shadow copy of the block's registers and velocity stores
  logic [COEF_W-1:0] mom_q = MOMENTUM_RST;
  logic [COEF_W-1:0] lr_q = LRATE_RST;
  logic nest_q = 1'b0;
  logic signed [VAL_W-1:0] w_vel [DEF_WEIGHT_ENTRIES];
  logic signed [VAL_W-1:0] b_vel [DEF_BIAS_ENTRIES];
  logic [DEF_WEIGHT_ENTRIES-1:0] w_live = '0;
  logic [DEF_BIAS_ENTRIES-1:0] b_live = '0;

  param_res_t pending_params[$];
  int unsigned mismatch_cnt = 0;
  bit idle_en = 1'b1;

  function automatic longint q16_round(input longint x);
    return (x + 32768) >>> 16;  // floor after adding half an LSB
  endfunction

  function automatic longint clamp32(input longint x, inout bit flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic param_res_t momentum_update(input upd_t it);
    param_res_t r;
    longint w, g, v, lrg, vn, term;
    bit clamped;
    clamped = 1'b0;
    r.sat = 1'b0;
    r.val = '0;
    if (it.cmd == CMD_CLEAR) begin
      w_live = '0;
      b_live = '0;
      return r;
    end
    if (it.sel == SEL_BIAS && it.idx >= DEF_BIAS_ENTRIES) begin
      r.val = it.param_in;
      return r;
    end
    w = it.param_in;
    g = it.gradient;
    if (it.sel == SEL_BIAS) v = b_live[it.idx] ? longint'(b_vel[it.idx]) : 0;
    else v = w_live[it.idx] ? longint'(w_vel[it.idx]) : 0;
    lrg = longint'(lr_q) * g;
    vn = clamp32(q16_round(longint'(mom_q) * v - lrg), clamped);
    if (it.sel == SEL_BIAS) begin
      b_vel[it.idx] = VAL_W'(vn);
      b_live[it.idx] = 1'b1;
    end else begin
      w_vel[it.idx] = VAL_W'(vn);
      w_live[it.idx] = 1'b1;
    end
    term = nest_q ? q16_round(longint'(mom_q) * vn - lrg) : vn;
    r.val = VAL_W'(clamp32(w + term, clamped));
    r.sat = clamped;
    return r;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MOMENTUM: mom_q = data;
      CFG_LRATE:    lr_q = data;
      CFG_NESTEROV: nest_q = data[0];
      default: ;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] hot_index(input int unsigned k);
    case (k)
      0: return 12'd0;
      1: return 12'd1;
      2: return 12'd17;
      3: return 12'd200;
      4: return 12'd255;
      5: return 12'd1024;
      6: return 12'd2730;
      default: return 12'd4095;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return VAL_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic upd_t rand_item(input int unsigned clear_pct);
    upd_t it;
    it.cmd = ($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_UPDATE;
    it.sel = $urandom_range(0, 1) ? SEL_BIAS : SEL_WEIGHT;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: it.idx = hot_index($urandom_range(0, 7));
      6, 7: it.idx = IDX_W'($urandom_range(0, 4095));
      8: it.idx = IDX_W'($urandom_range(DEF_BIAS_ENTRIES - 2, DEF_BIAS_ENTRIES + 1));
      default: it.idx = $urandom_range(0, 1) ? '1 : '0;
    endcase
    it.param_in = rand_q16();
    it.gradient = rand_q16();
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // result checker
  always @(posedge clk_i) begin : chk
    param_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_params.size() == 0) begin
        note_mismatch($sformatf("%0t: unexpected word param_out=%h saturated=%b",
                                $realtime, m_axis_tdata, m_axis_tuser[0]));
      end else begin
        e = pending_params.pop_front();
        if (m_axis_tdata !== e.val || m_axis_tuser[0] !== e.sat)
          note_mismatch($sformatf("%0t: param_out exp %h got %h, saturated exp %b got %b",
                                  $realtime, e.val, m_axis_tdata, e.sat, m_axis_tuser[0]));
      end
    end
  end

  // receiver inserts random stalls while idle_en is set; otherwise it is always ready
  int unsigned rx_hold = 0;
  always @(posedge clk_i) begin
    if (!idle_en) begin
      rx_hold = 0;
      m_axis_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // returns at the accepting edge with tvalid still high
  task automatic send_word(input upd_t it);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {4'b0, it.gradient, it.param_in, it.idx};
    s_axis_tuser <= {it.sel, it.cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_params.push_back(momentum_update(it));
  endtask

  task automatic send_update(input logic sel, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] w, input logic [VAL_W-1:0] g);
    upd_t it;
    it.cmd = CMD_UPDATE;
    it.sel = sel;
    it.idx = idx;
    it.param_in = w;
    it.gradient = g;
    send_word(it);
  endtask

  task automatic send_clear();
    upd_t it;
    it = rand_item(0);
    it.cmd = CMD_CLEAR;
    send_word(it);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_params.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // spare write goes last so a misdecoded index would show up in the results
  task automatic set_cfg(input logic [COEF_W-1:0] mom, input logic [COEF_W-1:0] lr,
                         input logic nest, input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx_l [4];
    logic [CFG_DATA_W-1:0] dat_l [4];
    int unsigned n;
    idx_l = '{CFG_MOMENTUM, CFG_LRATE, CFG_NESTEROV, CFG_SPARE};
    dat_l = '{mom, lr, CFG_DATA_W'(nest), {~mom[15:1], ~nest}};
    n = poke_spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_index_i <= idx_l[k];
      cfg_data_i <= dat_l[k];
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      apply_cfg(idx_l[k], dat_l[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_config();
    send_update(SEL_WEIGHT, 12'd0, 32'h0001_0000, 32'h0000_8000);
    send_update(SEL_WEIGHT, 12'd0, 32'h0001_0000, 32'h0000_8000);
    send_update(SEL_WEIGHT, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
    send_update(SEL_BIAS, 12'd255, 32'h7FFF_FFFF, 32'h8000_0000);
    send_update(SEL_BIAS, 12'd0, 32'hFFFF_0000, 32'h0003_0000);
  endtask

  task automatic test_bias_bounds();
    send_update(SEL_BIAS, 12'd256, 32'h1234_5678, 32'h7FFF_FFFF);
    send_update(SEL_BIAS, 12'd4095, 32'h8000_0001, 32'h8000_0000);
  endtask

  // ties land exactly on half an LSB in both directions
  task automatic test_rounding();
    wait_idle();
    set_cfg(16'h8000, 16'h8000, 1'b0, 1'b0);
    send_update(SEL_BIAS, 12'd10, 32'h0, 32'h0000_0001);
    send_update(SEL_BIAS, 12'd11, 32'h0, 32'hFFFF_FFFF);
    send_update(SEL_BIAS, 12'd12, 32'h0, 32'h0000_0003);
    send_update(SEL_BIAS, 12'd13, 32'h0, 32'hFFFF_FFFD);
  endtask

  task automatic test_saturation();
    wait_idle();
    set_cfg(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    repeat (2) send_update(SEL_WEIGHT, 12'd7, 32'h7FFF_FFFF, 32'h8000_0000);
    repeat (2) send_update(SEL_WEIGHT, 12'd8, 32'h8000_0000, 32'h7FFF_FFFF);
    send_update(SEL_WEIGHT, 12'd9, 32'h0000_0000, 32'h8000_0000);
  endtask

  task automatic test_nesterov();
    wait_idle();
    set_cfg(16'hFFFF, 16'h8000, 1'b1, 1'b0);
    send_update(SEL_WEIGHT, 12'd7, 32'h0000_0000, 32'h0001_0000);
    send_update(SEL_WEIGHT, 12'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_update(SEL_BIAS, 12'd255, 32'h0000_8000, 32'hFFFF_8000);
  endtask

  task automatic test_clear();
    upd_t it;
    it.cmd = CMD_CLEAR;
    it.sel = SEL_BIAS;
    it.idx = '1;
    it.param_in = '1;
    it.gradient = '1;
    send_word(it);
    send_update(SEL_WEIGHT, 12'd7, 32'h0000_0000, 32'h0001_0000);
    send_update(SEL_BIAS, 12'd255, 32'h0000_0000, 32'h0001_0000);
  endtask

  task automatic test_zero_coeffs();
    wait_idle();
    set_cfg(16'h0000, 16'h0000, 1'b1, 1'b1);
    send_update(SEL_WEIGHT, 12'd7, 32'h8765_4321, 32'h7FFF_FFFF);
    send_update(SEL_BIAS, 12'd3, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  // enough clears to wrap the generation tag; stale entries must still read as zero
  task automatic test_clear_wrap();
    wait_idle();
    set_cfg(16'($urandom), 16'($urandom), 1'($urandom), 1'b0);
    for (int k = 0; k < 8; k++) begin
      send_update(SEL_WEIGHT, hot_index(k), rand_q16(), rand_q16());
      send_update(SEL_BIAS, hot_index(k), rand_q16(), rand_q16());
    end
    for (int c = 0; c < 260; c++) begin
      send_clear();
      if (c % 16 == 5) send_word(rand_item(0));
    end
    for (int k = 0; k < 8; k++) begin
      send_update(SEL_WEIGHT, hot_index(k), rand_q16(), rand_q16());
      send_update(SEL_BIAS, hot_index(k), rand_q16(), rand_q16());
    end
  endtask

  task automatic test_random_training();
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: set_cfg(MOMENTUM_RST, LRATE_RST, 1'b1, 1'b0);
        1: set_cfg(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        default: set_cfg(16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
      endcase
      for (int i = 0; i < 44; i++) begin
        if (i % 40 == 0) idle_en = (ph != 4) && ($urandom_range(0, 3) != 0);
        send_word(rand_item(3));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_config();
    test_bias_bounds();
    test_rounding();
    test_saturation();
    test_nesterov();
    test_clear();
    test_zero_coeffs();
    test_clear_wrap();
    test_random_training();
    wait_idle();
    if (mismatch_cnt == 0 && pending_params.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/msgd_pkg.sv
rtl/msgd_vel_ram.sv
rtl/momentum_sgd_update_top.sv
tb/momentum_sgd_update_top_tb.sv
